### rtl/ttap_pkg.sv
// Shared widths, codes and control types for the travel time actuator position block.
`default_nettype none

package ttap_pkg;

  // Field widths
  localparam int unsigned TimeW  = 20;
  localparam int unsigned PosW   = 10;
  localparam int unsigned DlyW   = 15;
  localparam int unsigned ProdW  = PosW + TimeW;
  localparam int unsigned DivCntW = $clog2(ProdW + 1);

  // Full travel in thousandths, and register reset values
  localparam logic [PosW-1:0]  PosScale = 10'd1000;
  localparam logic [TimeW-1:0] TimeRst  = 20'd10000;

  // Reciprocal of the full scale, rounded up; exact for any product below 2^30
  localparam int unsigned RecipW     = 31;
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipProdW = ProdW + RecipW;
  localparam logic [RecipW-1:0] RecipScale =
    RecipW'(((64'd1 << RecipShift) + 64'(PosScale) - 64'd1) / 64'(PosScale));

  // Action codes of an input request
  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActStart = 2'd1,
    ActStop  = 2'd2,
    ActDelay = 2'd3
  } action_e;

  // Run modes
  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeOpen  = 2'd1,
    ModeClose = 2'd2,
    ModeWait  = 2'd3
  } mode_e;

  // Register indexes on the configuration port
  typedef enum logic {
    RegOpenTime  = 1'b0,
    RegCloseTime = 1'b1
  } reg_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul_first;
    logic mul_second;
    logic div_start;
    logic cap_pos;
    logic cap_other;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic calc_req;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/travel_time_actuator_position.sv
// Top level: configuration registers, controller and datapath of the position estimator.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  config   | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//  request  | in        | in_valid_i / in_ready_o   | action_i, direction_i, delay_ticks_i
//  result   | out       | out_valid_o / out_ready_i | motor_on_o, mode_o, position_o,
//           |           |                           | open_count_o, close_count_o
//
// A new request is accepted only after the last one commits. A counting tick (motor on) needs
// one run of the 30-step bit-serial divider plus the sequencing states; other requests commit directly.
// The result is held in the state registers; a new request is accepted while it waits, and
// its commit stalls until the waiting result is taken.
// Reset clears the state: motor off, closed, closing count and both travel times at 10000.
`default_nettype none

module travel_time_actuator_position (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic                        direction_i,
  input  logic [ttap_pkg::DlyW-1:0]   delay_ticks_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        motor_on_o,
  output logic [1:0]                  mode_o,
  output logic [ttap_pkg::PosW-1:0]   position_o,
  output logic [ttap_pkg::TimeW-1:0]  open_count_o,
  output logic [ttap_pkg::TimeW-1:0]  close_count_o
);
  import ttap_pkg::*;

  logic [TimeW-1:0] open_time_q;
  logic [TimeW-1:0] close_time_q;
  reg_e             reg_idx;
  cmd_t             cmd;
  sts_t             sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_time_q  <= TimeRst;
      close_time_q <= TimeRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegOpenTime:  open_time_q  <= pwdata[TimeW-1:0];
        RegCloseTime: close_time_q <= pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      RegOpenTime:  prdata = {{(32-TimeW){1'b0}}, open_time_q};
      RegCloseTime: prdata = {{(32-TimeW){1'b0}}, close_time_q};
      default:      prdata = '0;
    endcase
  end

  ttap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttap_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .open_time_i   (open_time_q),
    .close_time_i  (close_time_q),
    .action_i      (action_i),
    .direction_i   (direction_i),
    .delay_ticks_i (delay_ticks_i),
    .motor_on_o    (motor_on_o),
    .mode_o        (mode_o),
    .position_o    (position_o),
    .open_count_o  (open_count_o),
    .close_count_o (close_count_o)
  );

endmodule

`default_nettype wire

### rtl/ttap_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module ttap_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ttap_pkg::ProdW-1:0]  dividend_i,
  input  logic [ttap_pkg::TimeW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [ttap_pkg::ProdW-1:0]  quotient_o
);
  import ttap_pkg::*;

  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0]    quo_q, quo_d;
  logic [TimeW-1:0]    rem_q, rem_d;
  logic [TimeW-1:0]    dvs_q, dvs_d;
  logic [TimeW:0]      rem_sh;
  logic [TimeW:0]      rem_sub;
  logic                ge;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh  = {rem_q, quo_q[ProdW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(ProdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[ProdW-2:0], ge};
      rem_d  = ge ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != DivCntW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/ttap_dpath.sv
// Datapath: actuator state, counter update, shared multiplier and divider.
`default_nettype none

module ttap_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttap_pkg::cmd_t              cmd_i,
  output ttap_pkg::sts_t              sts_o,
  input  logic [ttap_pkg::TimeW-1:0]  open_time_i,
  input  logic [ttap_pkg::TimeW-1:0]  close_time_i,
  input  logic [1:0]                  action_i,
  input  logic                        direction_i,
  input  logic [ttap_pkg::DlyW-1:0]   delay_ticks_i,
  output logic                        motor_on_o,
  output logic [1:0]                  mode_o,
  output logic [ttap_pkg::PosW-1:0]   position_o,
  output logic [ttap_pkg::TimeW-1:0]  open_count_o,
  output logic [ttap_pkg::TimeW-1:0]  close_count_o
);
  import ttap_pkg::*;

  // Latched request
  action_e          act_q;
  logic             dir_q;
  logic [DlyW-1:0]  dly_in_q;

  // Actuator state
  logic             motor_q, motor_d;
  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TimeW-1:0] oc_q, oc_d;
  logic [TimeW-1:0] cc_q, cc_d;
  logic [DlyW-1:0]  dly_q, dly_d;

  // Working values of a counting tick
  logic [TimeW-1:0] cnt_new_q;
  logic             at_end_q;
  logic [ProdW-1:0] prod_q;
  logic [PosW-1:0]  pos_new_q;
  logic [TimeW-1:0] other_q;

  logic [TimeW-1:0] t_open, t_close, t_sel, cnt_sel;
  logic [TimeW:0]   cnt_inc;
  logic [TimeW-1:0] cnt_sat;
  logic [PosW-1:0]  mul_a;
  logic [TimeW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [RecipProdW-1:0] recip_prod;
  logic [TimeW-1:0] divisor;
  logic             div_busy;
  logic [ProdW-1:0] quotient;

  // A travel time of zero counts as one
  assign t_open  = (open_time_i  == '0) ? TimeW'(1) : open_time_i;
  assign t_close = (close_time_i == '0) ? TimeW'(1) : close_time_i;
  assign t_sel   = dir_q ? t_close : t_open;
  assign cnt_sel = dir_q ? cc_q : oc_q;

  // Advance the running counter and saturate at its travel time
  assign cnt_inc = {1'b0, cnt_sel} + 1'b1;
  assign cnt_sat = (cnt_inc > {1'b0, t_sel}) ? t_sel : cnt_inc[TimeW-1:0];

  // Multiplier operands: scale the count first, then scale the position back
  always_comb begin
    if (cmd_i.mul_second) begin
      mul_a = dir_q ? pos_new_q : PosScale - pos_new_q;
      mul_b = dir_q ? t_open : t_close;
    end else begin
      mul_a = PosScale;
      mul_b = dir_q ? t_close - cnt_new_q : cnt_new_q;
    end
  end
  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // Division by the full scale through its reciprocal
  assign recip_prod = RecipProdW'(prod_q) * RecipProdW'(RecipScale);

  // Divide by the travel time
  assign divisor = t_sel;

  ttap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Request latch and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= action_e'(action_i);
      dir_q    <= direction_i;
      dly_in_q <= delay_ticks_i;
    end
    if (cmd_i.prep) begin
      cnt_new_q <= cnt_sat;
      at_end_q  <= cnt_sat == t_sel;
    end
    if (cmd_i.mul_first || cmd_i.mul_second) begin
      prod_q <= prod;
    end
    if (cmd_i.cap_pos) begin
      pos_new_q <= quotient[PosW-1:0];
    end
    if (cmd_i.cap_other) begin
      other_q <= recip_prod[RecipShift +: TimeW];
    end
  end

  // State update at the end of a request
  always_comb begin
    motor_d = motor_q;
    mode_d  = mode_q;
    pos_d   = pos_q;
    oc_d    = oc_q;
    cc_d    = cc_q;
    dly_d   = dly_q;
    if (cmd_i.commit) begin
      case (act_q)
        ActTick: begin
          if (motor_q) begin
            pos_d = pos_new_q;
            if (dir_q) begin
              cc_d   = cnt_new_q;
              oc_d   = other_q;
              mode_d = ModeClose;
            end else begin
              oc_d   = cnt_new_q;
              cc_d   = other_q;
              mode_d = ModeOpen;
            end
            if (at_end_q) begin
              motor_d = 1'b0;
              mode_d  = ModeOff;
            end
          end
          // pending delay counts down and starts the motor at zero
          if (dly_q != '0) begin
            mode_d = ModeWait;
            dly_d  = dly_q - 1'b1;
            if (dly_q == DlyW'(1)) begin
              motor_d = 1'b1;
            end
          end
        end
        ActStart: begin
          motor_d = 1'b1;
          mode_d  = dir_q ? ModeClose : ModeOpen;
        end
        ActStop: begin
          dly_d   = '0;
          motor_d = 1'b0;
          mode_d  = ModeOff;
        end
        default: begin
          dly_d  = dly_in_q;
          mode_d = ModeWait;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_q <= 1'b0;
      mode_q  <= ModeOff;
      pos_q   <= '0;
      oc_q    <= '0;
      cc_q    <= TimeRst;
      dly_q   <= '0;
    end else begin
      motor_q <= motor_d;
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      oc_q    <= oc_d;
      cc_q    <= cc_d;
      dly_q   <= dly_d;
    end
  end

  // Status: a tick with the motor on needs the arithmetic
  assign sts_o.calc_req = (action_e'(action_i) == ActTick) && motor_q;
  assign sts_o.div_busy = div_busy;

  assign motor_on_o    = motor_q;
  assign mode_o        = mode_q;
  assign position_o    = pos_q;
  assign open_count_o  = oc_q;
  assign close_count_o = cc_q;

endmodule

`default_nettype wire

### rtl/ttap_ctrl.sv
// Controller: sequences one request through the datapath and owns both handshakes.
`default_nettype none

module ttap_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ttap_pkg::sts_t  sts_i,
  output ttap_pkg::cmd_t  cmd_o
);
  import ttap_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StMul1  = 4'd2;
  localparam logic [3:0] StDivS1 = 4'd3;
  localparam logic [3:0] StDivW1 = 4'd4;
  localparam logic [3:0] StMul2  = 4'd5;
  localparam logic [3:0] StRecip = 4'd6;
  localparam logic [3:0] StDone  = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free;

  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.load_in = 1'b1;
          state_d       = sts_i.calc_req ? StPrep : StDone;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StMul1;
      end
      StMul1: begin
        cmd_o.mul_first = 1'b1;
        state_d         = StDivS1;
      end
      StDivS1: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDivW1;
      end
      StDivW1: begin
        if (!sts_i.div_busy) begin
          cmd_o.cap_pos = 1'b1;
          state_d       = StMul2;
        end
      end
      StMul2: begin
        cmd_o.mul_second = 1'b1;
        state_d          = StRecip;
      end
      StRecip: begin
        // scale back by the reciprocal of the full scale
        cmd_o.cap_other = 1'b1;
        state_d         = StDone;
      end
      StDone: begin
        // commit only once the previous result has been taken
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result valid: cleared on take, set on commit
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
